>>> sv/rmc_pkg.sv
// ----------------------------------------------------------------------------
// rmc_pkg
// Shared types, constants and helpers of the range match cache.
// ----------------------------------------------------------------------------
`default_nettype none

package rmc_pkg;

   localparam int SLOTS_DEFAULT = 4;
   localparam int SLOT_W        = 4;
   localparam int PROBE_W       = 5;
   localparam int ID_W          = 16;
   localparam int POS_W         = 40;
   localparam int LEN_W         = 20;
   localparam int CNT_W         = 32;

   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   typedef enum logic [1:0] {
      OP_LOOKUP   = 2'd0,
      OP_REMEMBER = 2'd1,
      OP_CLEAR    = 2'd2,
      OP_IGNORE   = 2'd3
   } op_type;

   // scan record handed from cell to cell
   typedef struct packed {
      op_type              op;
      logic [POS_W-1:0]    index;
      logic [ID_W-1:0]     rid;
      logic [POS_W-1:0]    rbegin;
      logic [LEN_W-1:0]    rlen;
      logic                done;
      logic                hit;
      logic [ID_W-1:0]     fid;
      logic [SLOT_W-1:0]   slot;
      logic [PROBE_W-1:0]  probes;
      logic                fill;
      logic                have;
      logic [SLOT_W-1:0]   cand;
      logic [CNT_W-1:0]    cand_hits;
      logic [CNT_W-1:0]    cand_stamp;
   } token_type;

   // update broadcast to every cell when a scan completes
   typedef struct packed {
      logic                touch;
      logic                fill;
      logic                clear;
      logic [SLOT_W-1:0]   target;
      logic [CNT_W-1:0]    stamp;
      logic [ID_W-1:0]     rid;
      logic [POS_W-1:0]    rbegin;
      logic [LEN_W-1:0]    rlen;
   } commit_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      sat_inc = (v == CNT_MAX) ? CNT_MAX : v + 1'b1;
   endfunction

endpackage

`default_nettype wire

>>> sv/rmc_req_if.sv
// ----------------------------------------------------------------------------
// rmc_req_if
// Request and response channels of the range match cache: valid/ready plus beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface rmc_req_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    op;
   logic [rmc_pkg::POS_W-1:0]     index;
   logic [rmc_pkg::ID_W-1:0]      range_id;
   logic [rmc_pkg::POS_W-1:0]     range_begin;
   logic [rmc_pkg::LEN_W-1:0]     range_length;

   modport source (output valid, output op, output index, output range_id,
                   output range_begin, output range_length, input ready);
   modport sink   (input valid, input op, input index, input range_id,
                   input range_begin, input range_length, output ready);
endinterface

interface rmc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          hit;
   logic [rmc_pkg::ID_W-1:0]      found_id;
   logic [rmc_pkg::SLOT_W-1:0]    slot;
   logic [rmc_pkg::PROBE_W-1:0]   probes;

   modport source (output valid, output hit, output found_id, output slot,
                   output probes, input ready);
   modport sink   (input valid, input hit, input found_id, input slot,
                   input probes, output ready);
endinterface

`default_nettype wire

>>> sv/rmc_cell.sv
// ----------------------------------------------------------------------------
// rmc_cell
// One cache slot. Holds the stored range and its LFU bookkeeping, examines
// the scan record passing through and registers it for the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module rmc_cell #(
   parameter int CELL_ID = 0
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire rmc_pkg::token_type   in_tok,
   input  wire                       in_valid,
   input  wire                       hold,
   input  wire rmc_pkg::commit_type  commit,
   output rmc_pkg::token_type        out_tok,
   output logic                      out_valid
);

   localparam logic [rmc_pkg::SLOT_W-1:0] MY_SLOT = rmc_pkg::SLOT_W'(CELL_ID);

   logic                          valid_ff, valid_in;
   logic [rmc_pkg::ID_W-1:0]      id_ff, id_in;
   logic [rmc_pkg::POS_W-1:0]     begin_ff, begin_in;
   logic [rmc_pkg::LEN_W-1:0]     length_ff, length_in;
   logic [rmc_pkg::CNT_W-1:0]     hits_ff, hits_in;
   logic [rmc_pkg::CNT_W-1:0]     stamp_ff, stamp_in;
   rmc_pkg::token_type            tok_ff, tok_in;
   logic                          tvalid_ff, tvalid_in;
   logic                          match;
   logic                          better;

   // end of range formed one bit wider so it never wraps
   assign match = (in_tok.index >= begin_ff) &&
                  ({1'b0, in_tok.index} <
                   ({1'b0, begin_ff} + (rmc_pkg::POS_W+1)'(length_ff)));

   assign better = !in_tok.have || (hits_ff < in_tok.cand_hits) ||
                   ((hits_ff == in_tok.cand_hits) && (stamp_ff < in_tok.cand_stamp));

   always_comb begin
      tok_in = in_tok;
      if (!in_tok.done) begin
         case (in_tok.op)
            rmc_pkg::OP_LOOKUP: begin
               if (valid_ff) begin
                  tok_in.probes = in_tok.probes + 1'b1;
                  if (match) begin
                     tok_in.done = 1'b1;
                     tok_in.hit  = 1'b1;
                     tok_in.fid  = id_ff;
                     tok_in.slot = MY_SLOT;
                  end
               end
            end
            rmc_pkg::OP_REMEMBER: begin
               if (valid_ff && (id_ff == in_tok.rid)) begin
                  tok_in.done = 1'b1;
                  tok_in.hit  = 1'b1;
                  tok_in.slot = MY_SLOT;
               end else if (!valid_ff) begin
                  tok_in.done = 1'b1;
                  tok_in.fill = 1'b1;
                  tok_in.have = 1'b1;
                  tok_in.cand = MY_SLOT;
               end else if (better) begin
                  tok_in.have       = 1'b1;
                  tok_in.cand       = MY_SLOT;
                  tok_in.cand_hits  = hits_ff;
                  tok_in.cand_stamp = stamp_ff;
               end
            end
            default: ;
         endcase
      end
   end

   assign tvalid_in = in_valid || (tvalid_ff && hold);

   always_comb begin
      valid_in  = valid_ff;
      id_in     = id_ff;
      begin_in  = begin_ff;
      length_in = length_ff;
      hits_in   = hits_ff;
      stamp_in  = stamp_ff;
      if (commit.clear) begin
         valid_in = 1'b0;
      end
      if (commit.target == MY_SLOT) begin
         if (commit.touch) begin
            hits_in  = rmc_pkg::sat_inc(hits_ff);
            stamp_in = commit.stamp;
         end
         if (commit.fill) begin
            valid_in  = 1'b1;
            id_in     = commit.rid;
            begin_in  = commit.rbegin;
            length_in = commit.rlen;
            hits_in   = rmc_pkg::CNT_W'(1);
            stamp_in  = commit.stamp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         tvalid_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         tvalid_ff <= tvalid_in;
      end
   end

   // slot contents only matter once valid, so no reset
   always_ff @(posedge clock) begin
      id_ff     <= id_in;
      begin_ff  <= begin_in;
      length_ff <= length_in;
      hits_ff   <= hits_in;
      stamp_ff  <= stamp_in;
      if (in_valid) begin
         tok_ff <= tok_in;
      end
   end

   assign out_tok   = tok_ff;
   assign out_valid = tvalid_ff;

endmodule

`default_nettype wire

>>> sv/range_match_cache_lfu.sv
// ----------------------------------------------------------------------------
// range_match_cache_lfu
// Fully associative cache of index ranges with least-frequently-used
// replacement, built as a chain of slot cells.
//
// Usage:
//   req_chan carries one request beat: op (lookup, remember, clear, ignore), the
//   index to look up, or the id/begin/length of a range to remember.
//   rsp_chan returns exactly one response beat per request: hit, found_id,
//   slot and probes.
//   A request enters the first cell at the accept edge and moves one cell
//   per cycle; after the last cell the chosen slot is updated and the
//   response register loads. Only one request is in the chain at a time:
//   req_chan.ready stays low from accept until the scan commits.
//   A request may be accepted while the previous response still waits.
//   If rsp_chan is stalled, the finished scan waits at the end of the chain
//   and its slot update is deferred until the response register frees.
//   Reset empties all slots and zeroes the stamp counter; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module range_match_cache_lfu #(
   parameter int SLOTS = rmc_pkg::SLOTS_DEFAULT
) (
   input  wire        clock,
   input  wire        reset,
   rmc_req_if.sink    req_chan,
   rmc_rsp_if.source  rsp_chan
);

   rmc_pkg::token_type             tok   [SLOTS+1];
   logic                           tv    [SLOTS+1];
   rmc_pkg::token_type             head;
   rmc_pkg::token_type             last;
   rmc_pkg::commit_type            cm;

   logic                           accept;
   logic                           commit;
   logic                           busy_ff, busy_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [rmc_pkg::CNT_W-1:0]      stamp_ff, stamp_in;
   logic [rmc_pkg::CNT_W-1:0]      next_stamp;
   logic                           rsp_hit_ff;
   logic [rmc_pkg::ID_W-1:0]       rsp_fid_ff;
   logic [rmc_pkg::SLOT_W-1:0]     rsp_slot_ff, rsp_slot_in;
   logic [rmc_pkg::PROBE_W-1:0]    rsp_probes_ff;
   logic                           placed;

   assign req_chan.ready = !busy_ff;
   assign accept         = req_chan.valid && !busy_ff;

   always_comb begin
      head        = '0;
      head.op     = rmc_pkg::op_type'(req_chan.op);
      head.index  = req_chan.index;
      head.rid    = req_chan.range_id;
      head.rbegin = req_chan.range_begin;
      head.rlen   = req_chan.range_length;
   end

   assign tok[0] = head;
   assign tv[0]  = accept;

   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      rmc_cell #(
         .CELL_ID (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_tok    (tok[i]),
         .in_valid  (tv[i]),
         .hold      ((i == SLOTS-1) ? !commit : 1'b0),
         .commit    (cm),
         .out_tok   (tok[i+1]),
         .out_valid (tv[i+1])
      );
   end

   assign last       = tok[SLOTS];
   assign commit     = tv[SLOTS] && (!rsp_valid_ff || rsp_chan.ready);
   assign next_stamp = rmc_pkg::sat_inc(stamp_ff);
   assign placed     = !last.hit && (last.fill || last.have);

   always_comb begin
      cm        = '0;
      cm.target = last.hit ? last.slot : last.cand;
      cm.stamp  = next_stamp;
      cm.rid    = last.rid;
      cm.rbegin = last.rbegin;
      cm.rlen   = last.rlen;
      if (commit) begin
         unique case (last.op)
            rmc_pkg::OP_LOOKUP:   cm.touch = last.hit;
            rmc_pkg::OP_REMEMBER: begin
               cm.touch = last.hit;
               cm.fill  = placed;
            end
            rmc_pkg::OP_CLEAR:    cm.clear = 1'b1;
            default: ;
         endcase
      end
   end

   assign stamp_in     = (cm.touch || cm.fill) ? next_stamp : stamp_ff;
   assign busy_in      = accept || (busy_ff && !commit);
   assign rsp_valid_in = commit || (rsp_valid_ff && !rsp_chan.ready);
   assign rsp_slot_in  = (last.hit || ((last.op == rmc_pkg::OP_REMEMBER) && placed)) ?
                         cm.target : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         stamp_ff     <= '0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         stamp_ff     <= stamp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_hit_ff    <= last.hit;
         rsp_fid_ff    <= last.fid;
         rsp_slot_ff   <= rsp_slot_in;
         rsp_probes_ff <= last.probes;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.hit      = rsp_hit_ff;
   assign rsp_chan.found_id = rsp_fid_ff;
   assign rsp_chan.slot     = rsp_slot_ff;
   assign rsp_chan.probes   = rsp_probes_ff;

endmodule

`default_nettype wire
